// File: hw/rtl/per_row_range_histogram_assert.svh
// assertion macros for the histogram rtl
`ifndef PER_ROW_RANGE_HISTOGRAM_ASSERT_SVH
`define PER_ROW_RANGE_HISTOGRAM_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PRH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PRH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define PRH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/prh_pkg.sv
package prh_pkg;

    localparam int DEF_NUM_ROWS = 16;
    localparam int DEF_NUM_BINS = 64;

    localparam int VALUE_W     = 24;
    localparam int WIDTH_W     = 23;
    localparam int COUNT_W     = 32;
    localparam int BIN_INDEX_W = 6;
    localparam int ROW_IN_W    = 4;
    localparam int OP_W        = 2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // bit-serial divide: one quotient bit per cycle
    localparam int DIV_STEPS = VALUE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BIN_WIDTH  = 2'd2;

    localparam logic signed [VALUE_W-1:0] RST_RANGE_LOW  = 24'sd0;
    localparam logic signed [VALUE_W-1:0] RST_RANGE_HIGH = 24'sd10240;
    localparam logic [WIDTH_W-1:0]        RST_BIN_WIDTH  = 23'd160;

    typedef struct packed {
        logic signed [VALUE_W-1:0] range_low;
        logic signed [VALUE_W-1:0] range_high;
        logic [WIDTH_W-1:0]        bin_width;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   dividend;
        logic [WIDTH_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [BIN_INDEX_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] res;
        res = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
        return res;
    endfunction

endpackage

// File: hw/rtl/per_row_range_histogram.sv
// channel   direction  handshake             word
// --------  ---------  --------------------  ---------------------------------------------
// in        sink       i_valid / o_ready     i_operation, i_row, i_sample_value
// out       source     o_valid / i_ready     o_bin_index, o_bin_count, o_row_total,
//                                            o_row_out_count, o_last
// cfg       apb slave  psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// one word in flight: o_ready is high only while the controller is idle
// add sample in range: start, the 24-step bit-serial divider, then read and write of the counters
// add sample out of range: read-modify-write of the row counters
// read row: an address state and a data state per bin, held by output stalls, NUM_BINS words
// clear: a sweep over NUM_ROWS*NUM_BINS counter addresses; after reset the sweep alone
// reset is synchronous active low; an output word waits in its register for i_ready
`include "per_row_range_histogram_assert.svh"

module per_row_range_histogram
    import prh_pkg::*;
#(
    parameter int NUM_ROWS = DEF_NUM_ROWS,
    parameter int NUM_BINS = DEF_NUM_BINS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input word channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [OP_W-1:0]           i_operation,
    input  logic [ROW_IN_W-1:0]       i_row,
    input  logic signed [VALUE_W-1:0] i_sample_value,
    // result word channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [BIN_INDEX_W-1:0]    o_bin_index,
    output logic [COUNT_W-1:0]        o_bin_count,
    output logic [COUNT_W-1:0]        o_row_total,
    output logic [COUNT_W-1:0]        o_row_out_count,
    output logic                      o_last,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int BW = $clog2(NUM_BINS);
    localparam int AW = RW + BW;
    localparam int BIN_DEPTH = 1 << AW;
    localparam logic [BW-1:0] BIN_MAX = BW'(NUM_BINS - 1);
    localparam logic [RW-1:0] ROW_MAX = RW'(NUM_ROWS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_UPD_RD,
        S_UPD_WR,
        S_RD_ADDR,
        S_RD_DATA
    } t_state;

    t_state r_state;

    // configuration registers
    t_cfg cfg;

    prh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // bin number is found by a bit-serial divide of (value - low) by the width
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic               r_div_start;
    logic [VALUE_W-1:0] r_diff;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_diff;
    assign div_req.divisor  = cfg.bin_width;

    prh_div #(
        .NUM_BINS (NUM_BINS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // working registers; during clear they double as the sweep address
    logic [RW-1:0] r_row;
    logic [BW-1:0] r_bin;
    logic          r_in_range;

    // accept-time decode
    logic           accept;
    logic           row_ok;
    logic           in_range;
    logic [VALUE_W:0] diff_wide;
    logic           div_go;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign row_ok    = (32'(i_row) < NUM_ROWS);
    // both limits exclusive; an empty range sends every sample to the out count
    assign in_range  = (i_sample_value > cfg.range_low) && (i_sample_value < cfg.range_high);
    assign diff_wide = {i_sample_value[VALUE_W-1], i_sample_value}
                     - {cfg.range_low[VALUE_W-1], cfg.range_low};
    // divider starts on an accepted in-range sample of an existing row
    assign div_go    = accept && (i_operation == OP_ADD) && row_ok && in_range;

    // counter memories: bins addressed by {row, bin}, row word holds {out, total}
    logic [COUNT_W-1:0]   r_bin_mem [BIN_DEPTH];
    logic [2*COUNT_W-1:0] r_row_mem [NUM_ROWS];
    logic [COUNT_W-1:0]   r_bin_rd;
    logic [2*COUNT_W-1:0] r_row_rd;

    logic [AW-1:0]        mem_addr;
    logic                 bin_we;
    logic                 row_we;
    logic [COUNT_W-1:0]   n_bin_word;
    logic [2*COUNT_W-1:0] n_row_word;
    logic [COUNT_W-1:0]   rd_total;
    logic [COUNT_W-1:0]   rd_out;

    assign mem_addr = {r_row, r_bin};
    assign rd_total = r_row_rd[COUNT_W-1:0];
    assign rd_out   = r_row_rd[2*COUNT_W-1:COUNT_W];

    always_comb begin
        bin_we     = 1'b0;
        row_we     = 1'b0;
        n_bin_word = '0;
        n_row_word = '0;
        unique case (r_state)
            S_CLEAR: begin
                bin_we = 1'b1;
                row_we = 1'b1;
            end
            S_UPD_WR: begin
                bin_we     = r_in_range;
                row_we     = 1'b1;
                n_bin_word = sat_inc(r_bin_rd);
                n_row_word = r_in_range ? {rd_out, sat_inc(rd_total)}
                                        : {sat_inc(rd_out), rd_total};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            r_bin_mem[mem_addr] <= n_bin_word;
        end
        if (row_we) begin
            r_row_mem[r_row] <= n_row_word;
        end
        r_bin_rd <= r_bin_mem[mem_addr];
        r_row_rd <= r_row_mem[r_row];
    end

    // output register frees when empty or when its word is taken this cycle
    logic out_free;
    logic out_load;
    assign out_free = !o_valid || i_ready;
    // a read loads the next word as soon as the register frees
    assign out_load = (r_state == S_RD_DATA) && out_free;

    // controller and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_bin       <= '0;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_div_start <= div_go;
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    // sweep every bin of every row to zero
                    if (r_bin == BIN_MAX) begin
                        r_bin <= '0;
                        if (r_row == ROW_MAX) begin
                            r_row   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end else begin
                        r_bin <= r_bin + BW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        // a clear sweeps from row zero
                        r_row      <= (i_operation == OP_CLEAR) ? '0 : RW'(i_row);
                        r_bin      <= '0;
                        r_in_range <= in_range;
                        r_diff     <= diff_wide[VALUE_W-1:0];
                        unique case (i_operation)
                            OP_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            OP_ADD: begin
                                if (row_ok) begin
                                    if (in_range) begin
                                        r_state <= S_DIV;
                                    end else begin
                                        r_state <= S_UPD_RD;
                                    end
                                end
                            end
                            OP_READ: begin
                                if (row_ok) begin
                                    r_state <= S_RD_ADDR;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_bin   <= BW'(div_rsp.quot);
                        r_state <= S_UPD_RD;
                    end
                end
                S_UPD_RD: begin
                    r_state <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    r_state <= S_IDLE;
                end
                S_RD_ADDR: begin
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    // memory read data is held while the output stalls
                    if (out_free) begin
                        o_bin_index     <= BIN_INDEX_W'(r_bin);
                        o_bin_count     <= r_bin_rd;
                        o_row_total     <= rd_total;
                        o_row_out_count <= rd_out;
                        o_last          <= (r_bin == BIN_MAX);
                        if (r_bin == BIN_MAX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_bin   <= r_bin + BW'(1);
                            r_state <= S_RD_ADDR;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // divider only reports while the controller waits for it
    `PRH_ASSERT_IMPLIES(a_div_done_in_div, i_clk, i_rst_n,
        div_rsp.done, r_state == S_DIV, "divider done outside divide state")
    // the divider's bin never passes the last bin
    `PRH_ASSERT_IMPLIES(a_div_quot_range, i_clk, i_rst_n,
        div_rsp.done, BW'(div_rsp.quot) <= BIN_MAX, "bin index beyond last bin")
    // final bin of a read ends the read with last set
    `PRH_ASSERT_NEXT(a_read_last, i_clk, i_rst_n,
        (r_state == S_RD_DATA) && out_free && (r_bin == BIN_MAX),
        (r_state == S_IDLE) && o_valid && o_last, "row read did not end on last bin")
    // a result word only appears out of a row read
    `PRH_ASSERT_IMPLIES(a_valid_from_read, i_clk, i_rst_n,
        $rose(o_valid), $past(r_state) == S_RD_DATA, "result word outside a row read")

endmodule

// File: hw/rtl/prh_cfg.sv
module prh_cfg
    import prh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low  <= RST_RANGE_LOW;
            r_cfg.range_high <= RST_RANGE_HIGH;
            r_cfg.bin_width  <= RST_BIN_WIDTH;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RANGE_LOW:  r_cfg.range_low  <= pwdata[VALUE_W-1:0];
                REG_RANGE_HIGH: r_cfg.range_high <= pwdata[VALUE_W-1:0];
                REG_BIN_WIDTH:  r_cfg.bin_width  <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // signed limits read back sign extended
    always_comb begin
        unique case (reg_idx)
            REG_RANGE_LOW:
                prdata = {{(PDATA_W-VALUE_W){r_cfg.range_low[VALUE_W-1]}}, r_cfg.range_low};
            REG_RANGE_HIGH:
                prdata = {{(PDATA_W-VALUE_W){r_cfg.range_high[VALUE_W-1]}}, r_cfg.range_high};
            REG_BIN_WIDTH:
                prdata = {{(PDATA_W-WIDTH_W){1'b0}}, r_cfg.bin_width};
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/prh_div.sv
module prh_div
    import prh_pkg::*;
#(
    parameter int NUM_BINS = DEF_NUM_BINS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int BW = $clog2(NUM_BINS);
    localparam logic [BW-1:0] BIN_MAX = BW'(NUM_BINS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VALUE_W-1:0]   r_dvd;
    logic [WIDTH_W-1:0]   r_dvs;
    logic [WIDTH_W-1:0]   r_rem;
    logic [BW-1:0]        r_q;
    logic                 r_ovf;

    logic [VALUE_W-1:0]   trial;
    logic [VALUE_W:0]     trial_diff;
    logic                 q_bit;
    logic [BW-1:0]        quot_clamped;

    // restoring step: shift in the next dividend bit, try to subtract
    assign trial      = {r_rem, r_dvd[VALUE_W-1]};
    assign trial_diff = {1'b0, trial} - {2'b00, r_dvs};
    assign q_bit      = !trial_diff[VALUE_W];

    assign quot_clamped = (r_ovf || (r_q > BIN_MAX)) ? BIN_MAX : r_q;

    assign o_rsp.done = r_done;
    assign o_rsp.quot = BIN_INDEX_W'(quot_clamped);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            r_done <= r_busy && !i_req.start && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= (i_req.divisor == '0) ? WIDTH_W'(1) : i_req.divisor;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[VALUE_W-2:0], 1'b0};
                r_rem <= q_bit ? trial_diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
                // only the low quotient bits are kept, overflow is sticky
                r_q   <= BW'({r_q, q_bit});
                r_ovf <= r_ovf | r_q[BW-1];
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// File: verif/per_row_range_histogram_checker.sv
module per_row_range_histogram_checker
    import prh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [ROW_IN_W-1:0]    i_row,
    input  logic [VALUE_W-1:0]     i_sample_value,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [BIN_INDEX_W-1:0] i_bin_index,
    input  logic [COUNT_W-1:0]     i_bin_count,
    input  logic [COUNT_W-1:0]     i_row_total,
    input  logic [COUNT_W-1:0]     i_row_out_count,
    input  logic                   i_last,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [PDATA_W-1:0]     i_pwdata,
    input  logic                   i_pready,
    output int                     o_mismatches,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS        = DEF_NUM_ROWS;
    localparam int BINS        = DEF_NUM_BINS;
    localparam int MAX_PRINTED = 32;

    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin_index;
        logic [COUNT_W-1:0]     bin_count;
        logic [COUNT_W-1:0]     row_total;
        logic [COUNT_W-1:0]     row_out_count;
        logic                   last;
    } t_bin_readout;

    logic [COUNT_W-1:0] bin_tally [ROWS][BINS];
    logic [COUNT_W-1:0] in_tally  [ROWS];
    logic [COUNT_W-1:0] out_tally [ROWS];
    int                 lo_limit;
    int                 hi_limit;
    int                 bin_step;
    t_bin_readout       readout_q[$];
    int                 mismatch_count = 0;
    int                 pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic int sext24(input logic [VALUE_W-1:0] v);
        return $signed(v);
    endfunction

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    task automatic wipe_all();
        for (int r = 0; r < ROWS; r++) begin
            for (int b = 0; b < BINS; b++) begin
                bin_tally[r][b] = '0;
            end
            in_tally[r]  = '0;
            out_tally[r] = '0;
        end
    endtask

    // update the histogram copy for one accepted word, queue the readout of a read
    task automatic take_word(input logic [OP_W-1:0] op, input logic [ROW_IN_W-1:0] row,
                             input logic [VALUE_W-1:0] value);
        int           v;
        int           diff;
        int           w;
        int           k;
        t_bin_readout rd;
        v = sext24(value);
        case (op)
            OP_CLEAR: begin
                wipe_all();
            end
            OP_ADD: begin
                if (int'(row) < ROWS) begin
                    if (v > lo_limit && v < hi_limit) begin
                        diff = v - lo_limit;
                        w    = (bin_step == 0) ? 1 : bin_step;
                        k    = diff / w;
                        if (k > BINS - 1) k = BINS - 1;
                        bin_tally[row][k] = bump(bin_tally[row][k]);
                        in_tally[row]     = bump(in_tally[row]);
                    end else begin
                        out_tally[row] = bump(out_tally[row]);
                    end
                end
            end
            OP_READ: begin
                if (int'(row) < ROWS) begin
                    for (int b = 0; b < BINS; b++) begin
                        rd.bin_index     = BIN_INDEX_W'(b);
                        rd.bin_count     = bin_tally[row][b];
                        rd.row_total     = in_tally[row];
                        rd.row_out_count = out_tally[row];
                        rd.last          = (b == BINS - 1);
                        readout_q.push_back(rd);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_word();
        t_bin_readout want;
        if (readout_q.size() == 0) begin
            report_mismatch("unexpected word, bin_index", i_bin_index, 0);
        end else begin
            want = readout_q.pop_front();
            if (i_bin_index !== want.bin_index)
                report_mismatch("bin_index", i_bin_index, want.bin_index);
            if (i_bin_count !== want.bin_count)
                report_mismatch("bin_count", i_bin_count, want.bin_count);
            if (i_row_total !== want.row_total)
                report_mismatch("row_total", i_row_total, want.row_total);
            if (i_row_out_count !== want.row_out_count)
                report_mismatch("row_out_count", i_row_out_count, want.row_out_count);
            if (i_last !== want.last)
                report_mismatch("last", i_last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_all();
            lo_limit = sext24(RST_RANGE_LOW);
            hi_limit = sext24(RST_RANGE_HIGH);
            bin_step = int'(RST_BIN_WIDTH);
            readout_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_RANGE_LOW:  lo_limit = sext24(i_pwdata[VALUE_W-1:0]);
                    REG_RANGE_HIGH: hi_limit = sext24(i_pwdata[VALUE_W-1:0]);
                    REG_BIN_WIDTH:  bin_step = int'(i_pwdata[WIDTH_W-1:0]);
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) check_word();
            if (i_in_valid && i_in_ready) take_word(i_operation, i_row, i_sample_value);
        end
        pending_count = readout_q.size();
    end

endmodule

// File: verif/tb_per_row_range_histogram.sv
module tb_per_row_range_histogram;
    timeunit 1ns;
    timeprecision 1ps;
    import prh_pkg::*;

    // operation code outside the defined set, the block must ignore it
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    // settle time covers a full clear sweep of NUM_ROWS*NUM_BINS counters, plus margin
    localparam int SETTLE_CYCLES = 1100;
    localparam int ITEMS_PER_PHASE = 74;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [OP_W-1:0]           i_operation    = OP_CLEAR;
    logic [ROW_IN_W-1:0]       i_row          = '0;
    logic signed [VALUE_W-1:0] i_sample_value = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [BIN_INDEX_W-1:0]    o_bin_index;
    logic [COUNT_W-1:0]        o_bin_count;
    logic [COUNT_W-1:0]        o_row_total;
    logic [COUNT_W-1:0]        o_row_out_count;
    logic                      o_last;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [PADDR_W-1:0]        paddr   = '0;
    logic [PDATA_W-1:0]        pwdata  = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    int mismatches;
    int pending;

    // idle rates in percent, changed between phases
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // current limits, only used to aim samples at the interesting values
    int cur_low  = RST_RANGE_LOW;
    int cur_high = RST_RANGE_HIGH;

    always #5 i_clk = ~i_clk;

    per_row_range_histogram u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_row           (i_row),
        .i_sample_value  (i_sample_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bin_index     (o_bin_index),
        .o_bin_count     (o_bin_count),
        .o_row_total     (o_row_total),
        .o_row_out_count (o_row_out_count),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // predicts every bin readout and compares the result words
    per_row_range_histogram_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_operation     (i_operation),
        .i_row           (i_row),
        .i_sample_value  (i_sample_value),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_bin_index     (o_bin_index),
        .i_bin_count     (o_bin_count),
        .i_row_total     (o_row_total),
        .i_row_out_count (o_row_out_count),
        .i_last          (o_last),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // result side backpressure, one decision per cycle
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // one word on the input channel; returns at the falling edge after acceptance
    // with valid still high so back-to-back words need no extra assignment
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ROW_IN_W-1:0] row,
                             input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_row          <= row;
        i_sample_value <= value;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every readout word, then give a clear time to finish
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup cycle then access cycle; psel stays up for a following write
    task automatic apb_write(input logic [1:0] reg_idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    task automatic set_config(input int lo, input int hi, input int width);
        apb_write(REG_RANGE_LOW, lo);
        apb_write(REG_RANGE_HIGH, hi);
        apb_write(REG_BIN_WIDTH, width);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_low  = lo;
        cur_high = hi;
    endtask

    // mostly in-range values, some on the limits, some anywhere in the field
    function automatic logic [VALUE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0: v = $urandom;
            1: v = $urandom_range(1) ? -8388608 : 8388607;
            2: begin
                case ($urandom_range(3))
                    0: v = cur_low;
                    1: v = cur_low + 1;
                    2: v = cur_high - 1;
                    default: v = cur_high;
                endcase
            end
            default: begin
                if (cur_high - cur_low >= 2)
                    v = cur_low + 1 + int'($urandom_range(cur_high - cur_low - 2));
                else
                    v = $urandom;
            end
        endcase
        return VALUE_W'(v);
    endfunction

    task automatic run_random(input int count);
        int                  r;
        logic [OP_W-1:0]     op;
        logic [ROW_IN_W-1:0] row;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 2)       op = OP_CLEAR;
            else if (r < 6)  op = OP_NONE;
            else if (r < 18) op = OP_READ;
            else             op = OP_ADD;
            // favor a few rows so their counts build up
            if ($urandom_range(3) != 0)
                row = ROW_IN_W'($urandom_range(3));
            else
                row = ROW_IN_W'($urandom_range(15));
            send_word(op, row, pick_sample());
        end
    endtask

    initial begin
        int lo;
        int step;
        set_idle(24, 64);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the block zeroes its bins after reset
        wait_quiet();

        // directed words at reset settings: low 0.0, high 40.0, bin width 0.625
        send_word(OP_READ, 4'd0, '0);            // all zero after reset
        send_word(OP_ADD, 4'd0, 24'sd1);         // just above low, first bin
        send_word(OP_ADD, 4'd0, 24'sd159);       // top of first bin
        send_word(OP_ADD, 4'd0, 24'sd160);       // bottom of second bin
        send_word(OP_ADD, 4'd0, 24'sd10239);     // just below high, last bin
        send_word(OP_ADD, 4'd0, 24'sd0);         // equal to low is out
        send_word(OP_ADD, 4'd0, 24'sd10240);     // equal to high is out
        send_word(OP_ADD, 4'd0, 24'h800000);     // most negative value
        send_word(OP_ADD, 4'd0, 24'h7fffff);     // most positive value
        send_word(OP_NONE, 4'd0, 24'sd5);        // unused code, no effect
        send_word(OP_ADD, 4'd15, 24'sd5000);     // top row
        send_word(OP_READ, 4'd0, '0);
        send_word(OP_READ, 4'd15, '0);
        send_word(OP_CLEAR, 4'd0, '0);
        send_word(OP_READ, 4'd0, '0);            // cleared
        send_word(OP_READ, 4'd15, '0);
        run_random(ITEMS_PER_PHASE);

        // widest range and widest bins
        wait_quiet();
        set_config(-8388608, 8388607, 8388607);
        run_random(ITEMS_PER_PHASE);

        set_idle(64, 24);
        // unit bins over a wide range, most samples clamp to the last bin
        wait_quiet();
        set_config(-2560, 2560, 1);
        run_random(ITEMS_PER_PHASE);

        // zero width acts as one
        wait_quiet();
        set_config(-100, 100, 0);
        run_random(ITEMS_PER_PHASE);

        set_idle(0, 0);
        // low above high, every sample is out
        wait_quiet();
        set_config(1000, -1000, 77);
        run_random(ITEMS_PER_PHASE);

        // random setting whose range spans roughly 8..70 bin widths, clamped to the last bin
        lo   = int'($urandom_range(20000)) - 10000;
        step = $urandom_range(400, 1);
        wait_quiet();
        set_config(lo, lo + step * int'($urandom_range(70, 8)), step);
        run_random(ITEMS_PER_PHASE);

        wait_quiet();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: per_row_range_histogram.f
+incdir+hw/rtl
hw/rtl/prh_pkg.sv
hw/rtl/prh_cfg.sv
hw/rtl/prh_div.sv
hw/rtl/per_row_range_histogram.sv
verif/per_row_range_histogram_checker.sv
verif/tb_per_row_range_histogram.sv
